// File: rtl/rnta_pkg.sv
// package for the radix number to ascii block: field widths, character codes
// and the digit-to-character mapping; no dependencies
package rnta_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_PREC   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // item field widths
    localparam int VALUE_W  = 32;
    localparam int RADIX_W  = 6;
    localparam int PREC_W   = 6;
    localparam int FLAGS_W  = 4;
    localparam int CHAR_W   = 7;
    localparam int COUNT_W  = 6;
    localparam int DIGIT_W  = 6;

    // format flag bit positions
    localparam int FLAG_ZERO_PAD  = 0;
    localparam int FLAG_LOWERCASE = 1;
    localparam int FLAG_SIGNED    = 2;
    localparam int FLAG_SHOW_PLUS = 3;

    // legal base range
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

    localparam logic [DIGIT_W-1:0] DIGIT_SET_SIZE = 6'd36;
    localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

    // digit value to its character, 0-9 then letters in the chosen case
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                      input logic lower);
        logic [DIGIT_W-1:0] dm;
        logic [CHAR_W-1:0]  letter_base;
        dm = (d >= DIGIT_SET_SIZE) ? (d - DIGIT_SET_SIZE) : d;
        letter_base = lower ? CH_LOWER_A : CH_UPPER_A;
        if (dm < DECIMAL_DIGITS)
        begin
            digit_char = CH_ZERO + CHAR_W'(dm);
        end
        else
        begin
            digit_char = letter_base + CHAR_W'(dm - DECIMAL_DIGITS);
        end
    endfunction

endpackage

// File: rtl/rnta_in_if.sv
// number channel: valid/ready handshake carrying one number and its format
// depends on rnta_pkg for the field widths
interface rnta_in_if import rnta_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic [PREC_W-1:0]  precision;
    logic [FLAGS_W-1:0] format_flags;

    modport source (output valid, output value, output radix, output precision,
                    output format_flags, input ready);
    modport sink   (input valid, input value, input radix, input precision,
                    input format_flags, output ready);

endinterface

// File: rtl/rnta_out_if.sv
// text channel: valid/ready handshake carrying one ascii character per item
// depends on rnta_pkg for the field widths
interface rnta_out_if import rnta_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  out_char;
    logic               last_char;
    logic [COUNT_W-1:0] char_count;

    modport source (output valid, output out_char, output last_char,
                    output char_count, input ready);
    modport sink   (input valid, input out_char, input last_char,
                    input char_count, output ready);

endinterface

// File: rtl/rnta_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module rnta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/rnta_divider.sv
// bit-serial restoring divider: one quotient bit per cycle, small base divisor
// depends on rnta_pkg for the base and digit widths
module rnta_divider import rnta_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]    base,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIGIT_W-1:0]    remainder
);

    localparam int STEP_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [VALUE_BITS-1:0] quot_reg;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [RADIX_W-1:0]    base_reg;

    logic [DIGIT_W:0]      shifted;
    logic [DIGIT_W:0]      diff;
    logic                  fits;
    logic [DIGIT_W-1:0]    rem_step;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, quot_reg[VALUE_BITS-1]};
        diff     = shifted - {1'b0, base_reg};
        fits     = (shifted >= {1'b0, base_reg});
        rem_step = fits ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
    end

    // step sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            base_reg <= RADIX_MIN;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                quot_reg <= dividend;
                rem_reg  <= '0;
                base_reg <= base;
            end
            else if (busy_reg)
            begin
                quot_reg <= {quot_reg[VALUE_BITS-2:0], fits};
                rem_reg  <= rem_step;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(VALUE_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/radix_number_to_ascii_core.sv
// top level of the radix number to ascii block: control sequencer and text output
// depends on rnta_pkg, rnta_in_if, rnta_out_if, rnta_ram and rnta_divider

// Converts one number per input item into its ASCII text in base 2 to 36,
// sent as one output item per character, most significant first, with
// last_char and char_count marking the final character. The block takes one
// number at a time: num.ready is high only while it is idle. Digits come from
// the bit-serial divider, one division per digit, each digit written to the
// digit ram. Emission then passes through the sign step whether or not a sign
// is sent, a step per pad character plus one to leave padding, and a read
// step and an output step per digit, since each digit is read back from the
// digit ram; the text sink may stall any output step. The next number is
// accepted as soon as the last character has been loaded into the output
// register.
module radix_number_to_ascii_core import rnta_pkg::*; #(
    parameter int MAX_PREC   = DEF_MAX_PREC,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input logic        clk,
    input logic        rst_n,
    rnta_in_if.sink    num,
    rnta_out_if.source text
);

    localparam int DIGIT_DEPTH = (VALUE_BITS > MAX_PREC) ? VALUE_BITS : MAX_PREC;
    localparam int IDX_W       = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);
    localparam int TOT_W       = $clog2(DIGIT_DEPTH + 2);
    localparam int PCMP_W      = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_PAD,
        S_RD,
        S_DIG
    } state_t;

    state_t                state_reg,    state_next;
    logic                  start_reg,    start_next;
    logic [VALUE_BITS-1:0] dividend_reg, dividend_next;
    logic [RADIX_W-1:0]    radix_reg,    radix_next;
    logic [CNT_W-1:0]      prec_reg,     prec_next;
    logic [CNT_W-1:0]      ndig_reg,     ndig_next;
    logic [CNT_W-1:0]      pad_reg,      pad_next;
    logic [TOT_W-1:0]      total_reg,    total_next;
    logic                  sign_reg,     sign_next;
    logic [CHAR_W-1:0]     sign_char_reg, sign_char_next;
    logic                  zero_pad_reg, zero_pad_next;
    logic                  lower_reg,    lower_next;
    logic                  valid_reg,    valid_next;
    logic [CHAR_W-1:0]     char_reg,     char_next;
    logic                  last_reg,     last_next;
    logic [COUNT_W-1:0]    count_reg,    count_next;

    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DIGIT_W-1:0]    div_remainder;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [CNT_W-1:0]      rd_pos;
    logic [DIGIT_W-1:0]    rd_data;

    logic                  slot_free;
    logic [VALUE_BITS-1:0] raw_value;
    logic                  is_neg;
    logic [CNT_W-1:0]      ndig_inc;
    logic [CNT_W-1:0]      field_len;

    // digit divider
    rnta_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (dividend_reg),
        .base      (radix_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // digit store, least significant digit at the lowest address
    rnta_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_digit_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (div_remainder),
        .rd_addr (rd_pos[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign wr_en   = (state_reg == S_DIV) && div_done;
    assign wr_addr = ndig_reg[IDX_W-1:0];
    assign rd_pos  = ndig_reg - 1'b1;

    // output register may take a new item when empty or being drained
    assign slot_free = !valid_reg || text.ready;

    // next-state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        dividend_next  = dividend_reg;
        radix_next     = radix_reg;
        prec_next      = prec_reg;
        ndig_next      = ndig_reg;
        pad_next       = pad_reg;
        total_next     = total_reg;
        sign_next      = sign_reg;
        sign_char_next = sign_char_reg;
        zero_pad_next  = zero_pad_reg;
        lower_next     = lower_reg;
        valid_next     = valid_reg && !text.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        count_next     = count_reg;

        raw_value = VALUE_BITS'(num.value);
        is_neg    = num.format_flags[FLAG_SIGNED] && raw_value[VALUE_BITS-1];
        ndig_inc  = ndig_reg + 1'b1;
        field_len = (prec_reg > ndig_inc) ? prec_reg : ndig_inc;

        case (state_reg)
            S_IDLE:
            begin
                if (num.valid)
                begin
                    // clamp the base and precision, take the magnitude
                    if (num.radix < RADIX_MIN)
                    begin
                        radix_next = RADIX_MIN;
                    end
                    else if (num.radix > RADIX_MAX)
                    begin
                        radix_next = RADIX_MAX;
                    end
                    else
                    begin
                        radix_next = num.radix;
                    end
                    if (PCMP_W'(num.precision) > PCMP_W'(MAX_PREC))
                    begin
                        prec_next = CNT_W'(MAX_PREC);
                    end
                    else
                    begin
                        prec_next = CNT_W'(num.precision);
                    end
                    dividend_next  = is_neg ? (VALUE_BITS'(0) - raw_value) : raw_value;
                    sign_next      = is_neg || num.format_flags[FLAG_SHOW_PLUS];
                    sign_char_next = is_neg ? CH_MINUS : CH_PLUS;
                    zero_pad_next  = num.format_flags[FLAG_ZERO_PAD];
                    lower_next     = num.format_flags[FLAG_LOWERCASE];
                    ndig_next      = '0;
                    start_next     = 1'b1;
                    state_next     = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    ndig_next = ndig_inc;
                    if ((div_quotient != '0) && (ndig_inc < CNT_W'(DIGIT_DEPTH)))
                    begin
                        dividend_next = div_quotient;
                        start_next    = 1'b1;
                    end
                    else
                    begin
                        pad_next   = (prec_reg > ndig_inc) ? (prec_reg - ndig_inc) : '0;
                        total_next = TOT_W'(field_len) + TOT_W'(sign_reg);
                        state_next = S_SIGN;
                    end
                end
            end

            S_SIGN:
            begin
                if (!sign_reg)
                begin
                    state_next = S_PAD;
                end
                else if (slot_free)
                begin
                    valid_next = 1'b1;
                    char_next  = sign_char_reg;
                    last_next  = 1'b0;
                    count_next = '0;
                    state_next = S_PAD;
                end
            end

            S_PAD:
            begin
                if (pad_reg == '0)
                begin
                    state_next = S_RD;
                end
                else if (slot_free)
                begin
                    valid_next = 1'b1;
                    char_next  = zero_pad_reg ? CH_ZERO : CH_SPACE;
                    last_next  = 1'b0;
                    count_next = '0;
                    pad_next   = pad_reg - 1'b1;
                end
            end

            // wait for the registered ram read of the next digit
            S_RD:
            begin
                state_next = S_DIG;
            end

            S_DIG:
            begin
                if (slot_free)
                begin
                    valid_next = 1'b1;
                    char_next  = digit_char(rd_data, lower_reg);
                    ndig_next  = ndig_reg - 1'b1;
                    if (ndig_reg == CNT_W'(1))
                    begin
                        last_next  = 1'b1;
                        count_next = COUNT_W'(total_reg);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        count_next = '0;
                        state_next = S_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            dividend_reg  <= '0;
            radix_reg     <= RADIX_MIN;
            prec_reg      <= '0;
            ndig_reg      <= '0;
            pad_reg       <= '0;
            total_reg     <= '0;
            sign_reg      <= 1'b0;
            sign_char_reg <= CH_PLUS;
            zero_pad_reg  <= 1'b0;
            lower_reg     <= 1'b0;
            valid_reg     <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            dividend_reg  <= dividend_next;
            radix_reg     <= radix_next;
            prec_reg      <= prec_next;
            ndig_reg      <= ndig_next;
            pad_reg       <= pad_next;
            total_reg     <= total_next;
            sign_reg      <= sign_next;
            sign_char_reg <= sign_char_next;
            zero_pad_reg  <= zero_pad_next;
            lower_reg     <= lower_next;
            valid_reg     <= valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
        end
    end

    // channel drive
    assign num.ready       = (state_reg == S_IDLE);
    assign text.valid      = valid_reg;
    assign text.out_char   = char_reg;
    assign text.last_char  = last_reg;
    assign text.char_count = count_reg;

endmodule
